// ===== rtl/lifo_stack_with_peek_defines.svh =====
// Assertion macros used by the top-level file to check its own logic.
`ifndef LIFO_STACK_WITH_PEEK_DEFINES_SVH
`define LIFO_STACK_WITH_PEEK_DEFINES_SVH

// Same-cycle implication, sampled on clk and off while rst is high.
`define LSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and off while rst is high.
`define LSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lsp_pkg.sv =====
package lsp_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int ACT_BITS = 2;
  localparam int POS_BITS = 5;
  localparam int CAP_BITS = 5;
  localparam int ST_BITS  = 2;

  // Largest limit the capacity register can express.
  localparam int CAP_MAX = (1 << CAP_BITS) - 1;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(10);

  typedef enum logic [ACT_BITS-1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_DUMP = 2'd3
  } action_t;

  typedef enum logic [ST_BITS-1:0] {
    ST_OK     = 2'd0,
    ST_OVER   = 2'd1,
    ST_UNDER  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Move applied to every cell of the row in the same cycle.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_PUSH   = 2'd1,
    OP_POP    = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     tail;
  } cell_ctrl_t;

endpackage

// ===== rtl/lsp_cell.sv =====
module lsp_cell
  import lsp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic [WORD_BITS-1:0] from_above,
  input  logic [WORD_BITS-1:0] from_below,
  input  logic [WORD_BITS-1:0] from_top,
  output logic [WORD_BITS-1:0] word
);

  logic [WORD_BITS-1:0] word_next;

  // A push moves words down, a pop moves them up, and a rotation moves them
  // up while the tail cell picks up the old top word.
  always_comb begin
    unique case (ctrl.op)
      OP_PUSH:   word_next = from_above;
      OP_POP:    word_next = from_below;
      OP_ROTATE: word_next = ctrl.tail ? from_top : from_below;
      default:   word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== rtl/lsp_chain.sv =====
module lsp_chain
  import lsp_pkg::*;
#(
  parameter int CELLS     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int CIDX     = $clog2(CELLS)
) (
  input  logic                 clk,
  input  cell_op_t             op,
  input  logic [WORD_BITS-1:0] push_word,
  input  logic [CIDX-1:0]      tail_idx,
  input  logic [CIDX-1:0]      rd_idx,
  output logic [WORD_BITS-1:0] top_word,
  output logic [WORD_BITS-1:0] rd_word
);

  logic [WORD_BITS-1:0] words [CELLS];

  // Cell zero holds the top of the stack.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    cell_ctrl_t           ctrl;
    logic [WORD_BITS-1:0] above;
    logic [WORD_BITS-1:0] below;

    assign ctrl.op   = op;
    assign ctrl.tail = (CIDX'(i) == tail_idx);

    if (i == 0) begin : g_first
      assign above = push_word;
    end else begin : g_inner
      assign above = words[i-1];
    end

    if (i == CELLS - 1) begin : g_last
      assign below = words[i];
    end else begin : g_upper
      assign below = words[i+1];
    end

    lsp_cell #(
      .WORD_BITS(WORD_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .from_above(above),
      .from_below(below),
      .from_top  (words[0]),
      .word      (words[i])
    );
  end

  assign top_word = words[0];
  assign rd_word  = words[rd_idx];

endmodule

// ===== rtl/lifo_stack_with_peek.sv =====
// Bounded LIFO of signed words kept in a row of shift cells, cell zero being
// the top. Each input word carries an action in s_axis_tuser: push stores the
// value unless the count has reached the capacity limit (overflow), pop
// returns the top word (underflow and -1 on an empty stack), peek returns the
// word at a position counted from the top where 1 is the top (0 or a position
// beyond the count is rejected), and dump returns every stored word from top
// to bottom with tlast on the bottom one. Push, pop and peek are taken one
// per clock and give one result word each, so they sustain one word per
// cycle while m_axis_tready stays high. During a dump the row of cells
// rotates once per cycle while the output stage is free: the top word goes
// out and comes back in at the tail, so the stack is unchanged when the
// dump ends; no further input is taken until its last word has been loaded
// for output. A single registered output stage sits between the stack and
// m_axis. It frees in the same cycle its word is read, but while that word
// waits on m_axis_tready no input is taken and a dump does not advance. At
// most min(DEPTH, 31) words are ever stored, since the 5-bit capacity_limit
// bounds the count, and the row has that many cells. The user must write the
// limit through cfg_we/cfg_wdata only while the block is idle; the block
// does not enforce this itself. The limit resets to 10.
module lifo_stack_with_peek
  import lsp_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int IN_W     = ((WORD_BITS + POS_BITS + 7) / 8) * 8,
  localparam int OUT_W    = ((WORD_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CAP_BITS-1:0] cfg_wdata,     // capacity_limit
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [IN_W-1:0]     s_axis_tdata,  // push_value, peek_position, zero pad
  input  logic [ACT_BITS-1:0] s_axis_tuser,  // action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_W-1:0]    m_axis_tdata,  // read_word, zero pad
  output logic [ST_BITS-1:0]  m_axis_tuser,  // status
  output logic                m_axis_tlast   // last_of_run
);

`include "lifo_stack_with_peek_defines.svh"

  localparam int CELLS = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;
  localparam int CIDX  = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);

  localparam logic [CNT_W-1:0]     CNT_FULL = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0]     CNT_ONE  = CNT_W'(1);
  localparam logic [WORD_BITS-1:0] ERR_WORD = '1;

  // Input fields.
  action_t              action;
  logic [WORD_BITS-1:0] push_value;
  logic [POS_BITS-1:0]  peek_position;

  assign action        = action_t'(s_axis_tuser);
  assign push_value    = s_axis_tdata[WORD_BITS-1:0];
  assign peek_position = s_axis_tdata[WORD_BITS+POS_BITS-1:WORD_BITS];

  // Control state.
  logic [CAP_BITS-1:0] capacity_limit;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                dumping;
  logic                dumping_next;
  logic [CNT_W-1:0]    remain;
  logic [CNT_W-1:0]    remain_next;

  // Output stage.
  logic [WORD_BITS-1:0] read_word;
  status_t              status;
  logic                 last_of_run;
  logic                 load_out;
  logic [WORD_BITS-1:0] res_word;
  status_t              res_status;
  logic                 res_last;

  // Chain interface.
  cell_op_t             op;
  logic [WORD_BITS-1:0] top_word;
  logic [WORD_BITS-1:0] rd_word;
  logic [CIDX-1:0]      tail_idx;
  logic [CIDX-1:0]      rd_idx;
  logic [POS_BITS-1:0]  pos_m1;

  logic can_emit;
  logic accept;
  logic full;
  logic empty;
  logic bad_pos;

  assign can_emit      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !dumping && can_emit;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // The stack is full when the count meets either the register limit or the
  // number of cells; a limit lowered below the count simply blocks pushes.
  assign full    = (CAP_BITS'(count) >= capacity_limit) || (count == CNT_FULL);
  assign empty   = (count == '0);
  assign bad_pos = (peek_position == '0) || (peek_position > CAP_BITS'(count));

  // Position 1 is cell zero. Only used when the position is in range.
  assign pos_m1   = peek_position - POS_BITS'(1);
  assign rd_idx   = pos_m1[CIDX-1:0];
  assign tail_idx = CIDX'(count - CNT_ONE);

  always_comb begin
    op           = OP_HOLD;
    load_out     = 1'b0;
    res_word     = ERR_WORD;
    res_status   = ST_OK;
    res_last     = 1'b1;
    count_next   = count;
    dumping_next = dumping;
    remain_next  = remain;

    if (dumping) begin
      // Walk the rest of the stack, one word per free output slot.
      if (can_emit) begin
        op           = OP_ROTATE;
        load_out     = 1'b1;
        res_word     = top_word;
        res_last     = (remain == CNT_ONE);
        remain_next  = remain - CNT_ONE;
        dumping_next = (remain != CNT_ONE);
      end
    end else if (accept) begin
      load_out = 1'b1;
      unique case (action)
        ACT_PUSH: begin
          if (full) begin
            res_status = ST_OVER;
          end else begin
            op         = OP_PUSH;
            res_word   = '0;
            count_next = count + CNT_ONE;
          end
        end
        ACT_POP: begin
          if (empty) begin
            res_status = ST_UNDER;
          end else begin
            op         = OP_POP;
            res_word   = top_word;
            count_next = count - CNT_ONE;
          end
        end
        ACT_PEEK: begin
          if (bad_pos) begin
            res_status = ST_BADPOS;
          end else begin
            res_word = rd_word;
          end
        end
        ACT_DUMP: begin
          if (empty) begin
            res_status = ST_UNDER;
          end else begin
            // The top word goes out now; the rest follow while dumping.
            op           = OP_ROTATE;
            res_word     = top_word;
            res_last     = (count == CNT_ONE);
            remain_next  = count - CNT_ONE;
            dumping_next = (count != CNT_ONE);
          end
        end
        default: begin
          res_status = ST_UNDER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
      count          <= '0;
      dumping        <= 1'b0;
      remain         <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_limit <= cfg_wdata;
      end
      count   <= count_next;
      dumping <= dumping_next;
      remain  <= remain_next;
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (load_out) begin
      read_word   <= res_word;
      status      <= res_status;
      last_of_run <= res_last;
    end
  end

  lsp_chain #(
    .CELLS    (CELLS),
    .WORD_BITS(WORD_BITS)
  ) u_chain (
    .clk      (clk),
    .op       (op),
    .push_word(push_value),
    .tail_idx (tail_idx),
    .rd_idx   (rd_idx),
    .top_word (top_word),
    .rd_word  (rd_word)
  );

  assign m_axis_tdata = OUT_W'(read_word);
  assign m_axis_tuser = status;
  assign m_axis_tlast = last_of_run;

  // The stack never holds more words than there are cells.
  `LSP_ASSERT_NOW(a_count_bound, 1'b1, (count <= CNT_FULL), "stack count above cell count")

  // No new input is taken while a dump is walking the cells.
  `LSP_ASSERT_NOW(a_no_accept_in_dump, dumping, (!s_axis_tready), "input taken during dump")

  // A dump that sends its final word leaves the dump walk next cycle.
  `LSP_ASSERT_NEXT(a_dump_ends, (dumping && can_emit && (remain == CNT_ONE)), (!dumping), "dump did not end")

  // A successful push raises the count by exactly one.
  `LSP_ASSERT_NEXT(a_push_count, (accept && (action == ACT_PUSH) && !full), (count == ($past(count) + CNT_ONE)), "push count wrong")

endmodule
